// ===== rtl/oets_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package oets_pkg;

  // Default capacity of the element row.
  localparam int MAX_ELEMENTS_DEF = 64;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } out_t;

  // Commands from the controller to the element row.
  typedef struct packed {
    logic load_en;    // write the incoming element at the load index
    logic sort_en;    // run one compare-exchange phase
    logic odd_phase;  // phase parity: 0 orders (1,2),(3,4)..., 1 orders (0,1),(2,3)...
    logic shift_en;   // advance the row by one toward entry 0
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/oets_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oets_ctrl #(
  parameter int MAX_ELEMENTS = oets_pkg::MAX_ELEMENTS_DEF,
  parameter int CW           = $clog2(MAX_ELEMENTS + 1),
  parameter int IW           = $clog2(MAX_ELEMENTS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_final,
  output logic               out_overflow,
  output oets_pkg::cmd_t     cmd,
  output logic [IW-1:0]      load_idx,
  output logic [CW-1:0]      count
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] phase_r, phase_nxt;
  logic          dropped_r, dropped_nxt;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    phase_nxt   = phase_r;
    dropped_nxt = dropped_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    cmd.odd_phase = phase_r[0];
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r < CW'(MAX_ELEMENTS)) begin
            cmd.load_en = 1'b1;
            count_nxt   = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_SORT;
            phase_nxt = '0;
          end
        end
      end
      ST_SORT: begin
        cmd.sort_en = 1'b1;
        phase_nxt   = phase_r + CW'(1);
        if (phase_r == count_r - CW'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift_en = 1'b1;
          count_nxt    = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt   = ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      phase_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      phase_r   <= phase_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign load_idx     = count_r[IW-1:0];
  assign count        = count_r;
  assign out_final    = (count_r == CW'(1));
  assign out_overflow = dropped_r;

endmodule

`default_nettype wire

// ===== rtl/oets_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oets_dp #(
  parameter int MAX_ELEMENTS = oets_pkg::MAX_ELEMENTS_DEF,
  parameter int CW           = $clog2(MAX_ELEMENTS + 1),
  parameter int IW           = $clog2(MAX_ELEMENTS)
) (
  input  wire logic                                 clk,
  input  wire oets_pkg::cmd_t                       cmd,
  input  wire logic [IW-1:0]                        load_idx,
  input  wire logic [CW-1:0]                        count,
  input  wire logic signed [oets_pkg::DATA_W-1:0]   load_value,
  output logic signed [oets_pkg::DATA_W-1:0]        head_value
);

  logic signed [oets_pkg::DATA_W-1:0] cell_r   [MAX_ELEMENTS];
  logic signed [oets_pkg::DATA_W-1:0] cell_nxt [MAX_ELEMENTS];

  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    if (cmd.load_en) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        if (load_idx == IW'(i)) begin
          cell_nxt[i] = load_value;
        end
      end
    end else if (cmd.sort_en) begin
      // Pairs of one phase are disjoint, so every lane works on its own.
      for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
        if ((i[0] != cmd.odd_phase) && (CW'(i + 1) < count)) begin
          if (cell_r[i] > cell_r[i+1]) begin
            cell_nxt[i]   = cell_r[i+1];
            cell_nxt[i+1] = cell_r[i];
          end
        end
      end
    end else if (cmd.shift_en) begin
      for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
        cell_nxt[i] = cell_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  assign head_value = cell_r[0];

endmodule

`default_nettype wire

// ===== rtl/odd_even_transposition_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Odd-even transposition sorter. Send signed 32-bit elements one beat each on
// the in_ channel and flag the final one with last; the block then sorts and
// returns the run on the out_ channel in ascending order, final_res marking
// the last beat. Up to MAX_ELEMENTS elements are kept; further ones are
// dropped and every beat of that run carries overflow. For a run of n stored
// elements: loading takes one beat per cycle, the sort runs n compare-exchange
// phases (one phase per cycle across the whole register row), and the emit
// returns one beat per cycle while out_ready is high. The input is not ready
// during sort and emit; a new run may start in the cycle after the final
// result beat is taken.
module odd_even_transposition_sorter #(
  parameter int MAX_ELEMENTS = oets_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire oets_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output oets_pkg::out_t      out_data
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = $clog2(MAX_ELEMENTS);

  oets_pkg::cmd_t                     cmd;
  logic [IW-1:0]                      load_idx;
  logic [CW-1:0]                      count;
  logic                               out_final;
  logic                               out_overflow;
  logic signed [oets_pkg::DATA_W-1:0] head_value;

  // Controller: load, sort phases, emit.
  oets_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .CW           (CW),
    .IW           (IW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last      (in_data.last),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_final    (out_final),
    .out_overflow (out_overflow),
    .cmd          (cmd),
    .load_idx     (load_idx),
    .count        (count)
  );

  // Element row with its compare-exchange lanes.
  oets_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .CW           (CW),
    .IW           (IW)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .load_idx   (load_idx),
    .count      (count),
    .load_value (in_data.value),
    .head_value (head_value)
  );

  // Head of the row is the next result beat.
  assign out_data.sorted_value = head_value;
  assign out_data.final_res    = out_final;
  assign out_data.overflow     = out_overflow;

`ifndef SYNTHESIS
  // Never take input while results are being returned.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while results pending");

  // A closing beat stops intake until the run has been returned.
  a_close_stops_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last) |=> !in_ready)
    else $error("intake continued after closing beat");

  // After the final result beat, intake resumes.
  a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.final_res) |=> (in_ready && !out_valid))
    else $error("intake did not resume after final beat");

  // Result beats never show an empty run.
  a_nonempty_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (count != '0))
    else $error("emitting with empty row");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 11;
  localparam int CAPACITY      = oets_pkg::MAX_ELEMENTS_DEF;
  localparam int RANDOM_ITEMS  = 360;
  // Generous bound: many times what a correct run needs.
  localparam int TIMEOUT_CYCLES = 300000;
  // Cycles to watch for stray beats once nothing is expected any more.
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;
  // Long receiver hold-off; starts once this many beats have come back.
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 80;

  localparam logic signed [oets_pkg::DATA_W-1:0] MOST_NEG =
    {1'b1, {(oets_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [oets_pkg::DATA_W-1:0] MOST_POS =
    {1'b0, {(oets_pkg::DATA_W-1){1'b1}}};

  // Tracks the run being loaded and the sorted beats still owed by the block.
  class sort_scoreboard;
    logic signed [oets_pkg::DATA_W-1:0] run_elems[$];
    bit   run_dropped;
    oets_pkg::out_t owed_beats[$];
    int   mismatches;
    int   capacity;

    function new(int cap);
      capacity    = cap;
      run_dropped = 1'b0;
      mismatches  = 0;
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Odd-even transposition: phase p orders pairs starting at index 1 when p is
    // even and at index 0 when p is odd, n phases for n elements.
    function void sort_run();
      int n;
      int pos;
      logic signed [oets_pkg::DATA_W-1:0] tmp;
      n = run_elems.size();
      for (int p = 0; p < n; p++) begin
        pos = (p % 2 == 1) ? 0 : 1;
        for (; pos + 1 < n; pos += 2) begin
          if (run_elems[pos] > run_elems[pos+1]) begin
            tmp = run_elems[pos];
            run_elems[pos] = run_elems[pos+1];
            run_elems[pos+1] = tmp;
          end
        end
      end
    endfunction

    // Note one accepted input beat; a closing beat queues the whole sorted run.
    function void note_input(oets_pkg::in_t beat);
      oets_pkg::out_t exp_beat;
      if (run_elems.size() < capacity) run_elems.push_back(beat.value);
      else run_dropped = 1'b1;
      if (beat.last) begin
        sort_run();
        foreach (run_elems[k]) begin
          exp_beat.sorted_value = run_elems[k];
          exp_beat.final_res    = (k == run_elems.size() - 1);
          exp_beat.overflow     = run_dropped;
          owed_beats.push_back(exp_beat);
        end
        run_elems.delete();
        run_dropped = 1'b0;
      end
    endfunction

    // Compare one accepted result beat with the oldest owed beat.
    task check_result(oets_pkg::out_t got);
      oets_pkg::out_t want;
      if (owed_beats.size() == 0) begin
        report($sformatf("unexpected result value=%0d final_res=%0b overflow=%0b",
                         got.sorted_value, got.final_res, got.overflow));
      end else begin
        want = owed_beats.pop_front();
        if (got.sorted_value !== want.sorted_value)
          report($sformatf("sorted_value got %0d want %0d",
                           got.sorted_value, want.sorted_value));
        if (got.final_res !== want.final_res)
          report($sformatf("final_res got %0b want %0b (value %0d)",
                           got.final_res, want.final_res, want.sorted_value));
        if (got.overflow !== want.overflow)
          report($sformatf("overflow got %0b want %0b (value %0d)",
                           got.overflow, want.overflow, want.sorted_value));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  oets_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  oets_pkg::out_t out_data;

  sort_scoreboard sb;

  // Values of the run being sent, and sender burst bookkeeping.
  logic signed [oets_pkg::DATA_W-1:0] run_buf[$];
  int burst_left;
  int random_sent;
  int results_seen;

  odd_even_transposition_sorter #(
    .MAX_ELEMENTS(CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs or owes beats forever.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("simulation failed");
    $finish;
  end

  // Draw a value: mostly full-range random, with extremes and a narrow band
  // around zero so that duplicates and sign boundaries show up often.
  function automatic logic signed [oets_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2, 3:    return $signed($urandom_range(0, 16)) - 8;
      default: return $signed($urandom());
    endcase
  endfunction

  // Offer one beat and hold it until the handshake completes. Between bursts,
  // drop valid for a random gap; a zero gap keeps beats back to back.
  task send_beat(logic signed [oets_pkg::DATA_W-1:0] v, logic is_last);
    oets_pkg::in_t d;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    d.value  = v;
    d.last   = is_last;
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_input(d);
    burst_left--;
  endtask

  // Send run_buf as one array, last flagged on its final element.
  task send_run();
    foreach (run_buf[k]) send_beat(run_buf[k], k == run_buf.size() - 1);
  endtask

  // Hold the input quiet until every owed beat has come back.
  task wait_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Fill run_buf with n random values.
  task fill_random(int n);
    run_buf.delete();
    repeat (n) run_buf.push_back(pick_value());
  endtask

  // Receiver: check every accepted beat, stall on a mode that is redrawn at
  // random now and then, and once hold ready low for a long stretch so the block backs up.
  initial begin
    int cyc;
    int mode;
    int hold_left;
    bit hold_done;
    cyc = 0;
    mode = 0;
    hold_left = 0;
    hold_done = 1'b0;
    results_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_valid && out_ready) begin
          sb.check_result(out_data);
          results_seen++;
        end
        if (cyc % 40 == 0) mode = $urandom_range(0, 3);
        if (!hold_done && results_seen >= HOLD_AFTER) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            2:       out_ready <= (cyc % 3 == 0);
            default: out_ready <= ($urandom_range(0, 4) != 0);
          endcase
        end
        cyc++;
      end
    end
  end

  // Sender and overall sequence.
  initial begin
    int run_idx;
    int n;
    sb = new(CAPACITY);
    burst_left = 0;
    random_sent = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single-element runs at both extremes.
    run_buf = '{MOST_NEG};
    send_run();
    run_buf = '{MOST_POS};
    send_run();
    // Extremes, zero and sign neighbors in scrambled order.
    run_buf = '{MOST_POS, MOST_NEG, 0, -1, 1};
    send_run();
    // Descending with duplicates.
    run_buf = '{100, 7, 7, -3, -3, -100};
    send_run();
    // Already ascending.
    run_buf = '{-20, -5, 5, 20};
    send_run();
    // Two equal elements.
    run_buf = '{-42, -42};
    send_run();
    wait_drain();

    // Random runs: mostly short, with a completely full store, an overflow on
    // the closing element itself, and a few longer overflow runs mixed in.
    run_idx = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (run_idx)
        3:       n = CAPACITY;
        7:       n = CAPACITY + 1;
        11:      n = CAPACITY + 3;
        default: n = ($urandom_range(0, 19) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 4)
                                                  : $urandom_range(1, 12);
      endcase
      fill_random(n);
      send_run();
      random_sent += n;
      // Pause now and then until the block has handed back everything.
      if (run_idx == 5 || run_idx == 15) wait_drain();
      run_idx++;
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/oets_pkg.sv
rtl/oets_ctrl.sv
rtl/oets_dp.sv
rtl/odd_even_transposition_sorter.sv
sim/testbench.sv
